/* design/rtp_jitter_buffer_core_defines.svh */
// ----------------------------------------------------------------------------
// rtp_jitter_buffer_core_defines.svh
// Assertion macros used by the jitter buffer checker.
// ----------------------------------------------------------------------------
`ifndef RTP_JITTER_BUFFER_CORE_DEFINES_SVH
`define RTP_JITTER_BUFFER_CORE_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted
`define RTPJB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion, also checked during reset
`define RTPJB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/rtpjb_pkg.sv */
// ----------------------------------------------------------------------------
// rtpjb_pkg
// Types and constants of the RTP jitter buffer core.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpjb_pkg;

  // Stream payload widths
  localparam int SEQ_W      = 16;
  localparam int TAG_W      = 32;
  localparam int OCC_W      = 7;
  localparam int STAT_W     = 3;
  localparam int DEPTH_W    = 7;
  localparam int IN_DATA_W  = 48;  // seq, tag
  localparam int IN_USER_W  = 2;   // action, flush
  localparam int OUT_DATA_W = 56;  // seq, tag, occupancy, pad
  localparam int OUT_USER_W = 3;   // status
  localparam int ENTRY_W    = SEQ_W + TAG_W;

  localparam logic [DEPTH_W-1:0] RELEASE_DEPTH_RST = 7'd50;

  // Result codes
  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED = 3'd0,
    STAT_DUP      = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_RELEASED = 3'd3,
    STAT_NONE     = 3'd4
  } status_e;

  // Action codes
  typedef enum logic {
    ACT_PUT = 1'b0,
    ACT_GET = 1'b1
  } action_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DECIDE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_WRITE_NEW,
    ST_GET_RD,
    ST_GET_EVAL,
    ST_DONE
  } state_e;

  // Read address select
  typedef enum logic [1:0] {
    RD_HEAD,
    RD_POS,
    RD_SHIFT
  } rd_sel_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic    accept;
    rd_sel_e rd_sel;
    logic    pos_dec;
    logic    shift_init;
    logic    shift_wr;
    logic    write_new;
    logic    pop;
    logic    res_set;
    status_e res_code;
    logic    out_load;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic in_get;
    logic cnt_zero;
    logic scan_gt;
    logic scan_eq;
    logic pos_one;
    logic full;
    logic shift_empty;
    logic shift_last;
    logic go;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

/* design/rtp_jitter_buffer_core.sv */
// ----------------------------------------------------------------------------
// rtp_jitter_buffer_core
// Sorted reorder buffer for RTP packets with gap-aware release.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (low bit first)
// s_axis    in   tdata: packet_seq, packet_tag   tuser: action, flush
// m_axis    out  tdata: out_seq, out_tag, occupancy, pad   tuser: status
// cfg       in   cfg_wdata_i: release_depth (written when cfg_we_i is high)
//
// One item at a time. A get result rests on the registered head read; a get
// on an empty store answers without a read. An inserted put scans k entries
// from the tail and moves m entries up, one RAM access of the single read
// port per step; a duplicate is dropped during the scan and a full store
// after it. rst_ni clears counts and release state; the store needs no
// clearing. A stalled result holds in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_jitter_buffer_core #(
  parameter int CAPACITY = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [rtpjb_pkg::DEPTH_W-1:0]    cfg_wdata_i,   // release_depth
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [rtpjb_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // packet_seq, packet_tag
  input  wire logic [rtpjb_pkg::IN_USER_W-1:0]  s_axis_tuser,  // action, flush
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic      [rtpjb_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // out_seq, out_tag, occupancy
  output logic      [rtpjb_pkg::OUT_USER_W-1:0] m_axis_tuser   // status
);

  rtpjb_pkg::cmd_t  cmd;
  rtpjb_pkg::stat_t stat;

  rtpjb_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  rtpjb_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule

`default_nettype wire

/* design/rtpjb_ram.sv */
// ----------------------------------------------------------------------------
// rtpjb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpjb_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* design/rtpjb_ctrl.sv */
// ----------------------------------------------------------------------------
// rtpjb_ctrl
// Sequencer for put (scan, shift, insert) and get (read head, release).
// ----------------------------------------------------------------------------
`default_nettype none

module rtpjb_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire rtpjb_pkg::stat_t stat_i,
  output rtpjb_pkg::cmd_t     cmd_o
);

  rtpjb_pkg::state_e state_q, state_d;

  function automatic rtpjb_pkg::state_e rpkg_idle();
    return rtpjb_pkg::ST_IDLE;
  endfunction

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpkg_idle();
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.rd_sel     = rtpjb_pkg::RD_HEAD;
    cmd_o.res_code   = rtpjb_pkg::STAT_NONE;
    s_axis_tready    = 1'b0;
    unique case (state_q)
      rtpjb_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.accept = 1'b1;
          if (stat_i.in_get) begin
            if (stat_i.cnt_zero) begin
              cmd_o.res_set  = 1'b1;
              cmd_o.res_code = rtpjb_pkg::STAT_NONE;
              state_d        = rtpjb_pkg::ST_DONE;
            end else begin
              state_d = rtpjb_pkg::ST_GET_RD;
            end
          end else if (stat_i.cnt_zero) begin
            state_d = rtpjb_pkg::ST_DECIDE;
          end else begin
            state_d = rtpjb_pkg::ST_SCAN_RD;
          end
        end
      end
      rtpjb_pkg::ST_SCAN_RD: begin
        cmd_o.rd_sel = rtpjb_pkg::RD_POS;
        state_d      = rtpjb_pkg::ST_SCAN_CMP;
      end
      rtpjb_pkg::ST_SCAN_CMP: begin
        if (stat_i.scan_gt) begin
          cmd_o.pos_dec = 1'b1;
          state_d = stat_i.pos_one ? rtpjb_pkg::ST_DECIDE : rtpjb_pkg::ST_SCAN_RD;
        end else if (stat_i.scan_eq) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = rtpjb_pkg::STAT_DUP;
          state_d        = rtpjb_pkg::ST_DONE;
        end else begin
          state_d = rtpjb_pkg::ST_DECIDE;
        end
      end
      rtpjb_pkg::ST_DECIDE: begin
        if (stat_i.full) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = rtpjb_pkg::STAT_FULL;
          state_d        = rtpjb_pkg::ST_DONE;
        end else begin
          cmd_o.shift_init = 1'b1;
          state_d = stat_i.shift_empty ? rtpjb_pkg::ST_WRITE_NEW : rtpjb_pkg::ST_SHIFT_RD;
        end
      end
      rtpjb_pkg::ST_SHIFT_RD: begin
        cmd_o.rd_sel = rtpjb_pkg::RD_SHIFT;
        state_d      = rtpjb_pkg::ST_SHIFT_WR;
      end
      rtpjb_pkg::ST_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d = stat_i.shift_last ? rtpjb_pkg::ST_WRITE_NEW : rtpjb_pkg::ST_SHIFT_RD;
      end
      rtpjb_pkg::ST_WRITE_NEW: begin
        cmd_o.write_new = 1'b1;
        cmd_o.res_set   = 1'b1;
        cmd_o.res_code  = rtpjb_pkg::STAT_INSERTED;
        state_d         = rtpjb_pkg::ST_DONE;
      end
      rtpjb_pkg::ST_GET_RD: begin
        cmd_o.rd_sel = rtpjb_pkg::RD_HEAD;
        state_d      = rtpjb_pkg::ST_GET_EVAL;
      end
      rtpjb_pkg::ST_GET_EVAL: begin
        cmd_o.res_set  = 1'b1;
        cmd_o.pop      = stat_i.go;
        cmd_o.res_code = stat_i.go ? rtpjb_pkg::STAT_RELEASED : rtpjb_pkg::STAT_NONE;
        state_d        = rtpjb_pkg::ST_DONE;
      end
      rtpjb_pkg::ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = rtpjb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rtpjb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/rtpjb_dp.sv */
// ----------------------------------------------------------------------------
// rtpjb_dp
// Datapath: circular sorted store in RAM, item and result registers,
// release bookkeeping and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpjb_dp #(
  parameter int CAPACITY = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [rtpjb_pkg::DEPTH_W-1:0]        cfg_wdata_i,
  input  wire logic [rtpjb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  wire logic [rtpjb_pkg::IN_USER_W-1:0]      s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic      [rtpjb_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic      [rtpjb_pkg::OUT_USER_W-1:0]     m_axis_tuser,
  input  wire rtpjb_pkg::cmd_t                      cmd_i,
  output rtpjb_pkg::stat_t                          stat_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam int DW = (CW > rtpjb_pkg::DEPTH_W) ? CW : rtpjb_pkg::DEPTH_W;
  localparam int SEQ_W = rtpjb_pkg::SEQ_W;
  localparam int TAG_W = rtpjb_pkg::TAG_W;

  // Control registers
  logic [AW-1:0]                    head_q;
  logic [CW-1:0]                    count_q;
  logic [CW-1:0]                    pos_q;
  logic [CW-1:0]                    sh_q;
  logic [SEQ_W-1:0]                 last_q;
  logic                             rel_any_q;
  logic [rtpjb_pkg::DEPTH_W-1:0]    depth_q;
  logic                             out_valid_q;

  // Payload registers
  logic [SEQ_W-1:0]                 item_seq_q;
  logic [TAG_W-1:0]                 item_tag_q;
  logic                             item_flush_q;
  rtpjb_pkg::status_e               res_status_q;
  logic [SEQ_W-1:0]                 res_seq_q;
  logic [TAG_W-1:0]                 res_tag_q;
  logic [rtpjb_pkg::OUT_DATA_W-1:0] out_data_q;
  logic [rtpjb_pkg::OUT_USER_W-1:0] out_user_q;

  // RAM signals
  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr;
  logic [rtpjb_pkg::ENTRY_W-1:0]    ram_wdata;
  logic [AW-1:0]                    ram_raddr;
  logic [rtpjb_pkg::ENTRY_W-1:0]    ram_rdata;
  logic [SEQ_W-1:0]                 rd_seq;
  logic [TAG_W-1:0]                 rd_tag;
  logic [CW-1:0]                    pos_m1;
  logic [CW-1:0]                    sh_m1;
  logic [SEQ_W:0]                   last_p1;
  logic                             depth_ok;

  // Logical index to RAM address, relative to the head
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] idx);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(idx);
    if (sum >= SW'(CAPACITY)) begin
      sum = sum - SW'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  assign pos_m1 = pos_q - CW'(1);
  assign sh_m1  = sh_q - CW'(1);
  assign rd_seq = ram_rdata[rtpjb_pkg::ENTRY_W-1:TAG_W];
  assign rd_tag = ram_rdata[TAG_W-1:0];

  // Read address select
  always_comb begin
    unique case (cmd_i.rd_sel)
      rtpjb_pkg::RD_POS:   ram_raddr = phys(head_q, pos_m1);
      rtpjb_pkg::RD_SHIFT: ram_raddr = phys(head_q, sh_m1);
      default:             ram_raddr = head_q;
    endcase
  end

  // Write port: shift an entry up by one, or place the new one
  assign ram_we    = cmd_i.shift_wr | cmd_i.write_new;
  assign ram_waddr = cmd_i.shift_wr ? phys(head_q, sh_q) : phys(head_q, pos_q);
  assign ram_wdata = cmd_i.shift_wr ? ram_rdata : {item_seq_q, item_tag_q};

  rtpjb_ram #(
    .WIDTH (rtpjb_pkg::ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Release decision on the head entry
  assign last_p1  = {1'b0, last_q} + (SEQ_W + 1)'(1);
  assign depth_ok = DW'(count_q) >= DW'(depth_q);

  always_comb begin
    stat_o             = '0;
    stat_o.in_get      = (s_axis_tuser[0] == rtpjb_pkg::ACT_GET);
    stat_o.cnt_zero    = (count_q == '0);
    stat_o.scan_gt     = (rd_seq > item_seq_q);
    stat_o.scan_eq     = (rd_seq == item_seq_q);
    stat_o.pos_one     = (pos_q == CW'(1));
    stat_o.full        = (count_q == CW'(CAPACITY));
    stat_o.shift_empty = (count_q == pos_q);
    stat_o.shift_last  = (sh_m1 == pos_q);
    stat_o.go          = item_flush_q | ~rel_any_q | depth_ok |
                         (last_p1 == {1'b0, rd_seq});
    stat_o.out_free    = ~out_valid_q | m_axis_tready;
  end

  // Store bookkeeping and release state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      count_q   <= '0;
      pos_q     <= '0;
      sh_q      <= '0;
      last_q    <= '0;
      rel_any_q <= 1'b0;
      depth_q   <= rtpjb_pkg::RELEASE_DEPTH_RST;
    end else begin
      if (cfg_we_i) begin
        depth_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        pos_q <= count_q;
      end else if (cmd_i.pos_dec) begin
        pos_q <= pos_m1;
      end
      if (cmd_i.shift_init) begin
        sh_q <= count_q;
      end else if (cmd_i.shift_wr) begin
        sh_q <= sh_m1;
      end
      if (cmd_i.write_new) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.pop) begin
        count_q   <= count_q - CW'(1);
        head_q    <= (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);
        last_q    <= rd_seq;
        rel_any_q <= 1'b1;
      end
    end
  end

  // Item and result capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_seq_q   <= s_axis_tdata[SEQ_W-1:0];
      item_tag_q   <= s_axis_tdata[SEQ_W+TAG_W-1:SEQ_W];
      item_flush_q <= s_axis_tuser[1];
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_code;
      res_seq_q    <= cmd_i.pop ? rd_seq : '0;
      res_tag_q    <= cmd_i.pop ? rd_tag : '0;
    end
    if (cmd_i.out_load) begin
      out_data_q <= {1'b0, rtpjb_pkg::OCC_W'(count_q), res_tag_q, res_seq_q};
      out_user_q <= res_status_q;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

/* design/rtpjb_checker.sv */
// ----------------------------------------------------------------------------
// rtpjb_checker
// Port-level checks of the jitter buffer core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rtp_jitter_buffer_core_defines.svh"

module rtpjb_checker #(
  parameter int CAPACITY = 64
) (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             cfg_we_i,
  input wire logic [rtpjb_pkg::DEPTH_W-1:0]    cfg_wdata_i,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic [rtpjb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input wire logic [rtpjb_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [rtpjb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [rtpjb_pkg::OUT_USER_W-1:0] m_axis_tuser
);

  // No result is offered while reset is held
  `RTPJB_ASSERT_RST(a_no_out_in_rst, !rst_ni |-> !m_axis_tvalid, "result valid during reset")

  // A stalled result keeps its payload
  `RTPJB_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // One item in flight: the input closes right after a transfer
  `RTPJB_ASSERT(a_one_in_flight, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input ready right after a transfer")

  // Only a release carries a sequence number and tag; occupancy stays in range
  `RTPJB_ASSERT(a_out_fields, m_axis_tvalid |-> (m_axis_tuser == rtpjb_pkg::STAT_RELEASED || m_axis_tdata[47:0] == 48'd0) && (CAPACITY > 127 || m_axis_tdata[54:48] <= 7'(CAPACITY)), "result fields inconsistent")

endmodule

bind rtp_jitter_buffer_core rtpjb_checker #(.CAPACITY(CAPACITY)) u_rtpjb_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rtp_jitter_buffer_core. Put and get transfers are
// fed from a queue with random gaps, results are taken with random stalls.
// A sorted-store predictor forecasts every result, and each result is checked
// field by field against the oldest forecast. The release depth is changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import rtpjb_pkg::*;

  localparam int CAP        = 64;
  localparam int IDLE_LIMIT = 3000;  // worst-case put plus gaps and stalls
  localparam int TAIL_WAIT  = 300;

  typedef struct {
    action_e     action;
    logic [15:0] seq;
    logic [31:0] tag;
    logic        flush;
  } packet_t;

  typedef struct {
    status_e     status;
    logic [15:0] seq;
    logic [31:0] tag;
    logic [6:0]  occ;
  } outcome_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [DEPTH_W-1:0]    cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // packet_seq, packet_tag
  logic [IN_USER_W-1:0]  s_axis_tuser;   // action, flush
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // out_seq, out_tag, occupancy, pad
  logic [OUT_USER_W-1:0] m_axis_tuser;   // status

  // Stimulus and expectation queues
  packet_t  packets_to_send[$];
  outcome_t pending_results[$];
  int       queued_cnt;
  int       sent_cnt;
  int       errors;
  int       idle_cycles;
  int       gap_max;
  int       stall_max;

  // Predictor state: sorted store plus release bookkeeping
  logic [15:0]        buf_seq[$];
  logic [31:0]        buf_tag[$];
  logic [15:0]        last_out_seq;
  logic               released_once;
  logic [DEPTH_W-1:0] model_depth;

  // Driver / monitor handshake bookkeeping
  logic     in_xfer;
  logic     out_xfer;
  int       send_gap;
  int       recv_wait;
  packet_t  drv_pkt;
  packet_t  mon_pkt;
  outcome_t mon_res;
  logic [15:0] stream_cursor;

  rtp_jitter_buffer_core #(
    .CAPACITY(CAP)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // One step of the reorder buffer: returns the result of one item
  task automatic reorder_step(input packet_t p, output outcome_t r);
    int   pos;
    logic go;
    r = '{status: STAT_INSERTED, seq: '0, tag: '0, occ: '0};
    pos = 0;
    if (p.action == ACT_PUT) begin
      while (pos < buf_seq.size() && buf_seq[pos] < p.seq) pos++;
      if (pos < buf_seq.size() && buf_seq[pos] == p.seq) begin
        r.status = STAT_DUP;
      end else if (buf_seq.size() >= CAP) begin
        r.status = STAT_FULL;
      end else begin
        buf_seq.insert(pos, p.seq);
        buf_tag.insert(pos, p.tag);
      end
    end else if (buf_seq.size() == 0) begin
      r.status = STAT_NONE;
    end else begin
      // successor test uses int width, so 65535 never wraps to 0
      go = p.flush || !released_once || (buf_seq.size() >= int'(model_depth)) ||
           (int'(last_out_seq) + 1 == int'(buf_seq[0]));
      if (go) begin
        r.status      = STAT_RELEASED;
        r.seq         = buf_seq[0];
        r.tag         = buf_tag[0];
        buf_seq.delete(0);
        buf_tag.delete(0);
        last_out_seq  = r.seq;
        released_once = 1'b1;
      end else begin
        r.status = STAT_NONE;
      end
    end
    r.occ = 7'(buf_seq.size());
  endtask

  // Compare the result on the master side with one forecast
  task automatic check_result(input outcome_t want);
    logic [15:0] got_seq;
    logic [31:0] got_tag;
    logic [6:0]  got_occ;
    got_seq = m_axis_tdata[15:0];
    got_tag = m_axis_tdata[47:16];
    got_occ = m_axis_tdata[54:48];
    if (m_axis_tuser !== want.status) begin
      errors++;
      $display("%0t status: expected %0d, got %0d", $time, want.status, m_axis_tuser);
    end
    if (got_seq !== want.seq) begin
      errors++;
      $display("%0t out_seq: expected %0h, got %0h", $time, want.seq, got_seq);
    end
    if (got_tag !== want.tag) begin
      errors++;
      $display("%0t out_tag: expected %0h, got %0h", $time, want.tag, got_tag);
    end
    if (got_occ !== want.occ) begin
      errors++;
      $display("%0t occupancy: expected %0d, got %0d", $time, want.occ, got_occ);
    end
  endtask

  // Monitor: prediction on input transfers, checks on output transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_xfer  <= s_axis_tvalid && s_axis_tready;
      out_xfer <= m_axis_tvalid && m_axis_tready;
      if (cfg_we_i) model_depth = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        mon_pkt.action = action_e'(s_axis_tuser[0]);
        mon_pkt.flush  = s_axis_tuser[1];
        mon_pkt.seq    = s_axis_tdata[15:0];
        mon_pkt.tag    = s_axis_tdata[47:16];
        reorder_step(mon_pkt, mon_res);
        pending_results.insert(pending_results.size(), mon_res);
        sent_cnt++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none, got status %0d data %0h",
                   $time, m_axis_tuser, m_axis_tdata);
        end else begin
          check_result(pending_results[0]);
          pending_results.delete(0);
        end
      end
      // watchdog on cycles without any transfer
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Driver: one item per transfer, random gap between items
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_xfer)) begin
      if (send_gap > 0) begin
        send_gap      <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (packets_to_send.size() > 0) begin
        drv_pkt        = packets_to_send[0];
        packets_to_send.delete(0);
        s_axis_tdata  <= {drv_pkt.tag, drv_pkt.seq};
        s_axis_tuser  <= {drv_pkt.flush, drv_pkt.action};
        s_axis_tvalid <= 1'b1;
        send_gap      <= int'($urandom_range(0, gap_max));
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stall after each result transfer
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_xfer) recv_wait = int'($urandom_range(0, stall_max));
      if (recv_wait > 0) begin
        recv_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic add_item(input action_e a, input logic [15:0] s, input logic [31:0] t,
                          input logic f);
    packet_t p;
    p = '{action: a, seq: s, tag: t, flush: f};
    packets_to_send.insert(packets_to_send.size(), p);
    queued_cnt++;
  endtask

  // Hold the sender until every forecast result has been taken
  task automatic wait_drained();
    do @(negedge clk_i);
    while (!(sent_cnt == queued_cnt && pending_results.size() == 0));
  endtask

  task automatic write_depth(input logic [DEPTH_W-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly in-order packet stream with jitter, gaps and duplicates
  task automatic add_stream(input int count);
    int r;
    r = int'($urandom_range(0, 5));
    if (r == 0) stream_cursor = 16'($urandom_range(0, 65535));
    else if (r == 1) stream_cursor = 16'($urandom_range(65500, 65535));
    for (int k = 0; k < count; k++) begin
      r = int'($urandom_range(0, 99));
      if (r < 52) begin
        add_item(ACT_PUT, 16'(stream_cursor + $urandom_range(0, 3)), $urandom,
                 1'($urandom_range(0, 1)));
        r = int'($urandom_range(0, 9));
        if (r < 8) stream_cursor = stream_cursor + 16'd1;
        else if (r == 8) stream_cursor = stream_cursor + 16'd2;
      end else begin
        add_item(ACT_GET, 16'($urandom), $urandom, r >= 95);
      end
    end
  endtask

  task automatic add_noise(input int count);
    for (int k = 0; k < count; k++) begin
      add_item(action_e'($urandom_range(0, 1)), 16'($urandom), $urandom,
               1'($urandom_range(0, 1)));
    end
  endtask

  // Empty the store, fill it to capacity, then hit duplicate and full cases
  task automatic add_fill();
    logic [15:0] base;
    logic [15:0] order[CAP];
    logic [15:0] t;
    int          j;
    for (int k = 0; k < CAP; k++) add_item(ACT_GET, 16'($urandom), $urandom, 1'b1);
    base = 16'($urandom_range(0, 65535 - CAP));
    for (int k = 0; k < CAP; k++) order[k] = base + 16'(k);
    for (int k = 0; k < CAP; k++) begin
      j        = int'($urandom_range(0, CAP - 1));
      t        = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    for (int k = 0; k < CAP; k++) begin
      add_item(ACT_PUT, order[k], $urandom, 1'($urandom_range(0, 1)));
    end
    add_item(ACT_PUT, base + 16'($urandom_range(0, CAP - 1)), $urandom, 1'b0);  // dup, full
    add_item(ACT_PUT, base + 16'(CAP), $urandom, 1'b0);                          // full drop
    add_item(ACT_GET, 16'($urandom), $urandom, 1'b0);
  endtask

  // Main sequence
  initial begin
    int depth_plan[8];
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    in_xfer       = 1'b0;
    out_xfer      = 1'b0;
    send_gap      = 0;
    recv_wait     = 0;
    queued_cnt    = 0;
    sent_cnt      = 0;
    errors        = 0;
    idle_cycles   = 0;
    gap_max       = 6;
    stall_max     = 6;
    last_out_seq  = '0;
    released_once = 1'b0;
    model_depth   = RELEASE_DEPTH_RST;
    stream_cursor = 16'($urandom_range(0, 65535));

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset depth, first release, successor rule, no wrap
    add_item(ACT_GET, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);  // get on empty store
    add_item(ACT_PUT, 16'h0000, 32'h0000_0000, 1'b1);  // flush on put is ignored
    add_item(ACT_PUT, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    add_item(ACT_PUT, 16'h0000, 32'h1234_5678, 1'b0);  // duplicate
    add_item(ACT_GET, 16'h5555, 32'hAAAA_AAAA, 1'b0);  // nothing released yet
    add_item(ACT_GET, 16'h0000, 32'h0000_0000, 1'b0);  // gap, held back
    add_item(ACT_PUT, 16'h0001, 32'hA5A5_A5A5, 1'b0);
    add_item(ACT_GET, 16'h0000, 32'h0000_0000, 1'b0);  // successor
    add_item(ACT_GET, 16'h0000, 32'h0000_0000, 1'b1);  // flush through gap
    add_item(ACT_PUT, 16'h0000, 32'h5A5A_5A5A, 1'b0);
    add_item(ACT_GET, 16'h0000, 32'h0000_0000, 1'b0);  // 0 is no successor of 65535
    add_item(ACT_GET, 16'h0000, 32'h0000_0000, 1'b1);
    add_item(ACT_GET, 16'h0000, 32'h0000_0000, 1'b0);

    // Depth one: any held packet goes out
    write_depth(7'd1);
    add_item(ACT_PUT, 16'd300, 32'h0000_0300, 1'b0);
    add_item(ACT_PUT, 16'd200, 32'h0000_0200, 1'b0);
    add_item(ACT_GET, 16'h0000, 32'h0000_0000, 1'b0);
    add_item(ACT_GET, 16'h0000, 32'h0000_0000, 1'b0);
    add_item(ACT_GET, 16'h0000, 32'h0000_0000, 1'b0);

    // Depth zero: every get on a non-empty store releases
    write_depth(7'd0);
    add_item(ACT_PUT, 16'd7, 32'h0000_0007, 1'b0);
    add_item(ACT_GET, 16'h0000, 32'h0000_0000, 1'b0);
    add_item(ACT_PUT, 16'd9, 32'h0000_0009, 1'b0);
    add_item(ACT_GET, 16'h0000, 32'h0000_0000, 1'b0);

    // Random phases, each under its own release depth
    depth_plan = '{64, 127, 0, 1, 50, 2, 2, 65};
    depth_plan[5] = int'($urandom_range(2, 63));
    depth_plan[6] = int'($urandom_range(2, 63));
    for (int p = 0; p < 8; p++) begin
      write_depth(7'(depth_plan[p]));
      gap_max   = (p % 3 == 1) ? 0 : 6;
      stall_max = (p % 4 == 2) ? 0 : 6;
      if (depth_plan[p] == 64 || depth_plan[p] == 127) add_fill();
      add_stream(35);
      add_stream(35);
      add_noise(10);
      // sender holds off until the block has answered everything
      wait_drained();
      add_stream(35);
      add_noise(10);
    end

    // Let everything drain, then watch for stray results
    wait_drained();
    repeat (TAIL_WAIT) @(negedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
